FILE: rtl/core/sos_pkg.sv
// Shared types, codes and arithmetic helpers for the surface override scatter block.
// Used by sos_rdu, sos_core and the top level; depends on nothing.
`default_nettype none
package sos_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int PROB_BITS_DEF = 16;
  localparam int MAX_TRIES_DEF = 64;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int PROB_W = 17;

  localparam logic [2:0] REG_LOSS     = 3'd0;
  localparam logic [2:0] REG_SPECULAR = 3'd1;
  localparam logic [2:0] REG_SCATTER  = 3'd2;
  localparam logic [2:0] REG_MODE     = 3'd3;
  localparam logic [2:0] REG_SEED     = 3'd4;

  localparam logic [1:0] MODE_ISO       = 2'd0;
  localparam logic [1:0] MODE_LAMB_BACK = 2'd1;
  localparam logic [1:0] MODE_LAMB_FWD  = 2'd2;

  localparam logic [1:0] OUT_NONE   = 2'd0;
  localparam logic [1:0] OUT_ABSORB = 2'd1;
  localparam logic [1:0] OUT_BACK   = 2'd2;
  localparam logic [1:0] OUT_FWD    = 2'd3;

  localparam logic [1:0] SURF_TRANS = 2'd0;
  localparam logic [1:0] SURF_ABS   = 2'd1;
  localparam logic [1:0] SURF_SPEC  = 2'd2;
  localparam logic [1:0] SURF_LAMB  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_PICK, S_SPEC_DOT, S_SPEC_REF, S_ISO_A, S_ISO_B, S_ISO_SQ, S_ISO_CHK,
    S_ISO_ROOT, S_ISO_OUT, S_ISO_DOT, S_ISO_SIGN, S_LAM_W, S_LAM_SQ, S_LAM_CHK,
    S_LAM_ROOT, S_LAM_GO, S_LAM_WAIT, S_DONE
  } state_t;

  typedef enum logic {RDU_SQRT, RDU_DIV} rdu_op_t;

  typedef struct packed {
    logic        start;
    rdu_op_t     op;
    logic [63:0] x;
    logic [31:0] div;
  } rdu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } rdu_rsp_t;

  typedef struct packed {
    logic [PROB_W-1:0] prob_loss;
    logic [PROB_W-1:0] prob_specular;
    logic [PROB_W-1:0] prob_scatter;
    logic [1:0]        scatter_mode;
  } cfg_t;

  typedef struct packed {
    logic        load;
    logic [31:0] value;
  } seed_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] new_dir_x;
    logic signed [15:0] new_dir_y;
    logic signed [15:0] new_dir_z;
    logic [1:0]         outcome;
    logic [1:0]         surface_status;
    logic               retry_limit_hit;
  } res_t;

  function automatic logic [31:0] xs32(input logic [31:0] s);
    logic [31:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic logic signed [63:0] round_sh(input logic signed [63:0] v, input int s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7fff;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sos_in_if.sv
// Input item channel: photon direction and surface normal with valid and ready.
// Standalone; no package needed.
`default_nettype none
interface sos_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  modport source (output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sos_out_if.sv
// Result item channel: new direction, outcome, surface status and retry flag.
// Standalone; no package needed.
`default_nettype none
interface sos_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] new_dir_x;
  logic signed [15:0] new_dir_y;
  logic signed [15:0] new_dir_z;
  logic [1:0]         outcome;
  logic [1:0]         surface_status;
  logic               retry_limit_hit;
  modport source (output valid, new_dir_x, new_dir_y, new_dir_z, outcome, surface_status,
                  retry_limit_hit, input ready);
  modport sink (input valid, new_dir_x, new_dir_y, new_dir_z, outcome, surface_status,
                retry_limit_hit, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sos_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nothing.
`default_nettype none
module sos_mul (
  input  wire logic               clk,
  input  wire logic signed [33:0] a,
  input  wire logic signed [16:0] b,
  output logic signed [50:0]      p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
`default_nettype wire

FILE: rtl/core/sos_rdu.sv
// Iterative square root and division unit, one result bit per cycle on one subtractor.
// Depends on sos_pkg.
`default_nettype none
module sos_rdu (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  sos_pkg::rdu_req_t req,
  output sos_pkg::rdu_rsp_t rsp
);
  import sos_pkg::*;

  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  rdu_op_t op_r, op_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] q_r, q_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [31:0] div_r, div_nxt;
  logic [34:0] cand, sub;
  logic [35:0] diff;
  logic take;

  assign cand = (op_r == RDU_SQRT) ? {1'b0, rem_r[31:0], x_r[63:62]} :
                                     {2'b00, rem_r[31:0], x_r[63]};
  assign sub = (op_r == RDU_SQRT) ? {1'b0, q_r[31:0], 2'b01} : {3'b000, div_r};
  assign diff = {1'b0, cand} - {1'b0, sub};
  assign take = !diff[35];

  assign rsp.done = done_r;
  assign rsp.q = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    cnt_r <= cnt_nxt;
    x_r <= x_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    x_nxt = x_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    if (busy_r) begin
      rem_nxt = take ? diff[34:0] : cand;
      q_nxt = {q_r[62:0], take};
      x_nxt = (op_r == RDU_SQRT) ? {x_r[61:0], 2'b00} : {x_r[62:0], 1'b0};
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt = req.op;
      x_nxt = req.x;
      div_nxt = req.div;
      q_nxt = '0;
      rem_nxt = '0;
      cnt_nxt = (req.op == RDU_SQRT) ? 7'd32 : 7'd64;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/sos_core.sv
// Sequencer and datapath: random draws, outcome pick, reflection, scatter directions.
// Depends on sos_pkg, sos_mul and sos_rdu.
`default_nettype none
module sos_core #(
  parameter int FRAC_BITS = sos_pkg::FRAC_BITS_DEF,
  parameter int PROB_BITS = sos_pkg::PROB_BITS_DEF,
  parameter int MAX_TRIES = sos_pkg::MAX_TRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  sos_pkg::cfg_t     cfg,
  input  sos_pkg::seed_t    seed,
  input  wire logic        in_valid,
  input  sos_pkg::in_item_t in_item,
  output logic             in_ready,
  input  wire logic        out_free,
  output logic             deliver,
  output sos_pkg::res_t     res
);
  import sos_pkg::*;

  localparam int TW = $clog2(MAX_TRIES);
  localparam int RND_SPEC = 2 * FRAC_BITS - 1;
  localparam int RND_ISO = 32 - FRAC_BITS;
  localparam int DIV_SH = FRAC_BITS + 10;
  localparam longint unsigned NEAR_ZERO_SQ =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;

  state_t state_r, state_nxt;
  logic [31:0] rng_r, rng_nxt, rng_step;
  logic signed [15:0] v_r [3], v_nxt [3];
  logic signed [15:0] n_r [3], n_nxt [3];
  logic signed [15:0] d_r [3], d_nxt [3];
  logic signed [15:0] res_r [3], res_nxt [3];
  logic signed [16:0] w_r [3], w_nxt [3];
  logic signed [15:0] a_r, a_nxt, b_r, b_nxt;
  logic signed [35:0] acc_r, acc_nxt;
  logic [18:0] sc_r, sc_nxt;
  logic [31:0] s2_r, s2_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [TW-1:0] itry_r, itry_nxt, ltry_r, ltry_nxt;
  logic hit_r, hit_nxt;
  logic [1:0] outcome_r, outcome_nxt, status_r, status_nxt, last_r, last_nxt;

  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] p_r;
  logic signed [35:0] acc_add;
  rdu_req_t rdu_req;
  rdu_rsp_t rdu_rsp;

  logic [PROB_BITS-1:0] u;
  logic [32:0] ux, t1, t2, t3;
  logic iso_ok, lam_ok, w_neg;
  logic [16:0] w_mag, qs;
  logic signed [63:0] r2x, qv;

  sos_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(p_r));
  sos_rdu u_rdu (.clk(clk), .rst_n(rst_n), .req(rdu_req), .rsp(rdu_rsp));

  function automatic logic signed [15:0] sel16(input logic signed [15:0] x [3],
                                               input logic [1:0] i);
    logic signed [15:0] r;
    case (i)
      2'd0: r = x[0];
      2'd1: r = x[1];
      default: r = x[2];
    endcase
    return r;
  endfunction

  function automatic logic signed [16:0] sel17(input logic signed [16:0] x [3],
                                               input logic [1:0] i);
    logic signed [16:0] r;
    case (i)
      2'd0: r = x[0];
      2'd1: r = x[1];
      default: r = x[2];
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rng_r <= 32'd1;
      last_r <= SURF_TRANS;
    end else begin
      state_r <= state_nxt;
      rng_r <= rng_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    n_r <= n_nxt;
    d_r <= d_nxt;
    w_r <= w_nxt;
    res_r <= res_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
    sc_r <= sc_nxt;
    s2_r <= s2_nxt;
    idx_r <= idx_nxt;
    itry_r <= itry_nxt;
    ltry_r <= ltry_nxt;
    hit_r <= hit_nxt;
    outcome_r <= outcome_nxt;
    status_r <= status_nxt;
  end

  assign rng_step = xs32(rng_r);
  assign u = rng_r[31 -: PROB_BITS];
  assign ux = 33'(u);
  assign t1 = 33'(cfg.prob_loss);
  assign t2 = t1 + 33'(cfg.prob_specular);
  assign t3 = t2 + 33'(cfg.prob_scatter);
  assign acc_add = acc_r + 36'(p_r);
  assign iso_ok = acc_r <= (36'sd1 <<< 30);
  assign lam_ok = 64'($unsigned(acc_r)) >= NEAR_ZERO_SQ;
  assign r2x = 64'(acc_r);
  assign w_neg = sel17(w_r, idx_r) < 0;
  assign w_mag = w_neg ? 17'(-sel17(w_r, idx_r)) : 17'(sel17(w_r, idx_r));
  assign qs = (rdu_rsp.q > 64'd65536) ? 17'd65536 : rdu_rsp.q[16:0];
  assign qv = 64'(qs);

  assign res.new_dir_x = res_r[0];
  assign res.new_dir_y = res_r[1];
  assign res.new_dir_z = res_r[2];
  assign res.outcome = outcome_r;
  assign res.surface_status = status_r;
  assign res.retry_limit_hit = hit_r;

  always_comb begin
    state_nxt = state_r;
    rng_nxt = rng_r;
    v_nxt = v_r;
    n_nxt = n_r;
    d_nxt = d_r;
    w_nxt = w_r;
    res_nxt = res_r;
    a_nxt = a_r;
    b_nxt = b_r;
    acc_nxt = acc_r;
    sc_nxt = sc_r;
    s2_nxt = s2_r;
    idx_nxt = idx_r;
    itry_nxt = itry_r;
    ltry_nxt = ltry_r;
    hit_nxt = hit_r;
    outcome_nxt = outcome_r;
    status_nxt = status_r;
    last_nxt = last_r;
    mul_a = '0;
    mul_b = '0;
    rdu_req = '0;
    deliver = 1'b0;
    in_ready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          v_nxt[0] = in_item.dir_x;
          v_nxt[1] = in_item.dir_y;
          v_nxt[2] = in_item.dir_z;
          n_nxt[0] = in_item.norm_x;
          n_nxt[1] = in_item.norm_y;
          n_nxt[2] = in_item.norm_z;
          rng_nxt = rng_step;
          hit_nxt = 1'b0;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        itry_nxt = '0;
        ltry_nxt = '0;
        acc_nxt = '0;
        idx_nxt = 2'd0;
        if (ux < t1) begin
          res_nxt = v_r;
          outcome_nxt = OUT_ABSORB;
          status_nxt = SURF_ABS;
          state_nxt = S_DONE;
        end else if (ux < t2) begin
          outcome_nxt = OUT_BACK;
          status_nxt = SURF_SPEC;
          state_nxt = S_SPEC_DOT;
        end else if (ux < t3 && (cfg.scatter_mode == MODE_ISO ||
                                 cfg.scatter_mode == MODE_LAMB_BACK ||
                                 cfg.scatter_mode == MODE_LAMB_FWD)) begin
          state_nxt = S_ISO_A;
        end else begin
          res_nxt = v_r;
          outcome_nxt = OUT_NONE;
          status_nxt = SURF_TRANS;
          state_nxt = S_DONE;
        end
      end
      S_SPEC_DOT: begin
        mul_a = 34'(sel16(n_r, idx_r));
        mul_b = 17'(sel16(v_r, idx_r));
        if (idx_r != 2'd0) acc_nxt = acc_add;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          idx_nxt = 2'd0;
          state_nxt = S_SPEC_REF;
        end
      end
      S_SPEC_REF: begin
        mul_a = acc_r[33:0];
        mul_b = 17'(sel16(n_r, idx_r));
        case (idx_r)
          2'd1: res_nxt[0] = sat16(64'(v_r[0]) - round_sh(64'(p_r), RND_SPEC));
          2'd2: res_nxt[1] = sat16(64'(v_r[1]) - round_sh(64'(p_r), RND_SPEC));
          2'd3: res_nxt[2] = sat16(64'(v_r[2]) - round_sh(64'(p_r), RND_SPEC));
          default: ;
        endcase
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) state_nxt = S_DONE;
      end
      S_ISO_A: begin
        rng_nxt = rng_step;
        a_nxt = {~rng_step[31], rng_step[30:16]};
        state_nxt = S_ISO_B;
      end
      S_ISO_B: begin
        rng_nxt = rng_step;
        b_nxt = {~rng_step[31], rng_step[30:16]};
        acc_nxt = '0;
        idx_nxt = 2'd0;
        state_nxt = S_ISO_SQ;
      end
      S_ISO_SQ: begin
        mul_a = 34'((idx_r == 2'd0) ? a_r : b_r);
        mul_b = 17'((idx_r == 2'd0) ? a_r : b_r);
        if (idx_r != 2'd0) acc_nxt = acc_add;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd2) state_nxt = S_ISO_CHK;
      end
      S_ISO_CHK: begin
        if (iso_ok || itry_r == TW'(MAX_TRIES - 1)) begin
          if (!iso_ok) hit_nxt = 1'b1;
          rdu_req.start = 1'b1;
          rdu_req.op = RDU_SQRT;
          rdu_req.x = iso_ok ? 64'((36'sd1 <<< 30) - acc_r) : 64'd0;
          d_nxt[2] = sat16(round_sh((r2x <<< 3) - (64'sd1 <<< 32), RND_ISO));
          state_nxt = S_ISO_ROOT;
        end else begin
          itry_nxt = itry_r + TW'(1);
          state_nxt = S_ISO_A;
        end
      end
      S_ISO_ROOT: begin
        if (rdu_rsp.done) begin
          sc_nxt = {rdu_rsp.q[15:0], 3'b000};
          idx_nxt = 2'd0;
          state_nxt = S_ISO_OUT;
        end
      end
      S_ISO_OUT: begin
        mul_a = 34'(sc_r);
        mul_b = 17'((idx_r == 2'd0) ? a_r : b_r);
        if (idx_r == 2'd1) d_nxt[0] = sat16(round_sh(64'(p_r), RND_ISO));
        if (idx_r == 2'd2) d_nxt[1] = sat16(round_sh(64'(p_r), RND_ISO));
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd2) begin
          acc_nxt = '0;
          idx_nxt = 2'd0;
          state_nxt = (cfg.scatter_mode == MODE_ISO) ? S_ISO_DOT : S_LAM_W;
        end
      end
      S_ISO_DOT: begin
        mul_a = 34'(sel16(d_r, idx_r));
        mul_b = 17'(sel16(n_r, idx_r));
        if (idx_r != 2'd0) acc_nxt = acc_add;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) state_nxt = S_ISO_SIGN;
      end
      S_ISO_SIGN: begin
        res_nxt = d_r;
        if (acc_r < 0) begin
          outcome_nxt = OUT_BACK;
          status_nxt = last_r;
        end else begin
          outcome_nxt = OUT_FWD;
          status_nxt = SURF_TRANS;
        end
        state_nxt = S_DONE;
      end
      S_LAM_W: begin
        for (int i = 0; i < 3; i++) begin
          w_nxt[i] = (cfg.scatter_mode == MODE_LAMB_BACK) ? 17'(d_r[i]) - 17'(n_r[i]) :
                                                            17'(d_r[i]) + 17'(n_r[i]);
        end
        if (cfg.scatter_mode == MODE_LAMB_BACK) begin
          outcome_nxt = OUT_BACK;
          status_nxt = SURF_LAMB;
        end else begin
          outcome_nxt = OUT_FWD;
          status_nxt = SURF_TRANS;
        end
        acc_nxt = '0;
        idx_nxt = 2'd0;
        state_nxt = S_LAM_SQ;
      end
      S_LAM_SQ: begin
        mul_a = 34'(sel17(w_r, idx_r));
        mul_b = sel17(w_r, idx_r);
        if (idx_r != 2'd0) acc_nxt = acc_add;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) state_nxt = S_LAM_CHK;
      end
      S_LAM_CHK: begin
        if (lam_ok || ltry_r == TW'(MAX_TRIES - 1)) begin
          if (!lam_ok) hit_nxt = 1'b1;
          rdu_req.start = 1'b1;
          rdu_req.op = RDU_SQRT;
          rdu_req.x = 64'($unsigned(acc_r)) << 20;
          state_nxt = S_LAM_ROOT;
        end else begin
          ltry_nxt = ltry_r + TW'(1);
          itry_nxt = '0;
          state_nxt = S_ISO_A;
        end
      end
      S_LAM_ROOT: begin
        if (rdu_rsp.done) begin
          s2_nxt = rdu_rsp.q[31:0];
          idx_nxt = 2'd0;
          if (rdu_rsp.q == 64'd0) begin
            for (int i = 0; i < 3; i++) res_nxt[i] = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LAM_GO;
          end
        end
      end
      S_LAM_GO: begin
        rdu_req.start = 1'b1;
        rdu_req.op = RDU_DIV;
        rdu_req.x = (64'(w_mag) << DIV_SH) + 64'(s2_r >> 1);
        rdu_req.div = s2_r;
        state_nxt = S_LAM_WAIT;
      end
      S_LAM_WAIT: begin
        if (rdu_rsp.done) begin
          case (idx_r)
            2'd0: res_nxt[0] = sat16(w_neg ? -qv : qv);
            2'd1: res_nxt[1] = sat16(w_neg ? -qv : qv);
            default: res_nxt[2] = sat16(w_neg ? -qv : qv);
          endcase
          idx_nxt = idx_r + 2'd1;
          state_nxt = (idx_r == 2'd2) ? S_DONE : S_LAM_GO;
        end
      end
      S_DONE: begin
        if (out_free) begin
          deliver = 1'b1;
          last_nxt = status_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (seed.load) rng_nxt = (seed.value == 32'd0) ? 32'd1 : seed.value;
  end
endmodule
`default_nettype wire

FILE: rtl/core/surface_override_scatter.sv
// Top level: configuration registers, input handshake and output register.
// Depends on sos_pkg, sos_in_if, sos_out_if and sos_core.
//
// Channel  Kind          Moves
// in_ch    valid/ready   one photon item: direction and surface normal
// out_ch   valid/ready   one result item per input item
// cfg_*    APB write/rd  probabilities, scatter mode, generator seed
//
// Absorb and not-triggered items go from the pick straight to output; specular reflection
// adds a dot product and the reflected components. An isotropic try draws and squares two
// values; the accepted one adds a root on the shared unit and scaling, then a sign check
// in mode 0. A Lambertian draw adds a length check; the last adds a root and three divisions.
// Rejected tries repeat, up to MAX_TRIES per loop; reset is synchronous.
// A finished item waits in the output register; the core stalls only while it is full.
`default_nettype none
module surface_override_scatter #(
  parameter int FRAC_BITS = sos_pkg::FRAC_BITS_DEF,
  parameter int PROB_BITS = sos_pkg::PROB_BITS_DEF,
  parameter int MAX_TRIES = sos_pkg::MAX_TRIES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  sos_in_if.sink                          in_ch,
  sos_out_if.source                       out_ch,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [sos_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [sos_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [sos_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import sos_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic [31:0] seed_r, seed_nxt;
  seed_t seed;
  logic wr;
  logic [2:0] reg_idx;
  in_item_t item;
  res_t res, out_r;
  logic out_valid_r, out_free, deliver, core_ready;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx = cfg_paddr[CFG_AW-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    seed_nxt = seed_r;
    seed.load = 1'b0;
    seed.value = cfg_pwdata;
    if (wr) begin
      case (reg_idx)
        REG_LOSS: cfg_nxt.prob_loss = cfg_pwdata[PROB_W-1:0];
        REG_SPECULAR: cfg_nxt.prob_specular = cfg_pwdata[PROB_W-1:0];
        REG_SCATTER: cfg_nxt.prob_scatter = cfg_pwdata[PROB_W-1:0];
        REG_MODE: cfg_nxt.scatter_mode = cfg_pwdata[1:0];
        REG_SEED: begin
          seed_nxt = cfg_pwdata;
          seed.load = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOSS: cfg_prdata = 32'(cfg_r.prob_loss);
      REG_SPECULAR: cfg_prdata = 32'(cfg_r.prob_specular);
      REG_SCATTER: cfg_prdata = 32'(cfg_r.prob_scatter);
      REG_MODE: cfg_prdata = 32'(cfg_r.scatter_mode);
      REG_SEED: cfg_prdata = seed_r;
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
      seed_r <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      seed_r <= seed_nxt;
      if (deliver) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) out_r <= res;
  end

  assign out_free = !out_valid_r || out_ch.ready;

  assign item.dir_x = in_ch.dir_x;
  assign item.dir_y = in_ch.dir_y;
  assign item.dir_z = in_ch.dir_z;
  assign item.norm_x = in_ch.norm_x;
  assign item.norm_y = in_ch.norm_y;
  assign item.norm_z = in_ch.norm_z;
  assign in_ch.ready = core_ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.new_dir_x = out_r.new_dir_x;
  assign out_ch.new_dir_y = out_r.new_dir_y;
  assign out_ch.new_dir_z = out_r.new_dir_z;
  assign out_ch.outcome = out_r.outcome;
  assign out_ch.surface_status = out_r.surface_status;
  assign out_ch.retry_limit_hit = out_r.retry_limit_hit;

  sos_core #(
    .FRAC_BITS(FRAC_BITS),
    .PROB_BITS(PROB_BITS),
    .MAX_TRIES(MAX_TRIES)
  ) u_core (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .seed(seed),
    .in_valid(in_ch.valid),
    .in_item(item),
    .in_ready(core_ready),
    .out_free(out_free),
    .deliver(deliver),
    .res(res)
  );
endmodule
`default_nettype wire
